// ===== hdl/rmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmm_pkg: shared types and constants for the rolling midpoint min/max block
// Item formats, the command passed from front to back, and size constants.
// ----------------------------------------------------------------------------
package rmm_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int SUM_W       = 33;
    localparam int INDEX_W     = 32;
    localparam int WLEN_W      = 11;
    localparam int WLEN_RESET  = 14;
    localparam int MAX_WINDOW  = 1024;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_of_series;
        logic                       last_of_series;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] extreme_sum;
        logic [INDEX_W-1:0]      output_index;
    } out_item_t;

    // One classified sample, queued for the back end
    typedef struct packed {
        logic                       block_end;
        logic                       emit;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] pmax;
        logic signed [SAMPLE_W-1:0] pmin;
        logic [INDEX_W-1:0]         index;
    } cmd_t;

    typedef struct packed {
        logic in_pass;
        logic pop;
    } bk_status_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_PASS,
        BK_DONE
    } bk_state_t;

endpackage
`default_nettype wire

// ===== hdl/rmm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmm_front: sample intake and classification
// Tracks block position, fill and result counts and the running prefix
// extrema, and turns each sample into a command for the back end.
// ----------------------------------------------------------------------------
module rmm_front
    import rmm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WLEN_W-1:0] cfg_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    logic [WLEN_W-1:0]          wlen_reg, wlen_next;
    logic [ADDR_W-1:0]          bp_reg, bp_next;
    logic [WLEN_W-1:0]          fill_reg, fill_next;
    logic [INDEX_W-1:0]         rcnt_reg, rcnt_next;
    logic signed [SAMPLE_W-1:0] pmax_reg, pmax_next;
    logic signed [SAMPLE_W-1:0] pmin_reg, pmin_next;

    logic [WLEN_W-1:0]          p;
    logic [ADDR_W-1:0]          bp_c;
    logic [WLEN_W-1:0]          fill_c, fill_new;
    logic [INDEX_W-1:0]         rcnt_c;
    logic signed [SAMPLE_W-1:0] pmax_c, pmin_c, pmax_new, pmin_new, s;
    logic                       blk_end, emit, accept;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        p = wlen_reg;
        if (wlen_reg == '0)
            p = WLEN_W'(1);
        else if (wlen_reg > WLEN_W'(MAX_WINDOW))
            p = WLEN_W'(MAX_WINDOW);

        s      = in_data.sample;
        bp_c   = in_data.first_of_series ? '0 : bp_reg;
        fill_c = in_data.first_of_series ? '0 : fill_reg;
        rcnt_c = in_data.first_of_series ? '0 : rcnt_reg;
        pmax_c = in_data.first_of_series ? '0 : pmax_reg;
        pmin_c = in_data.first_of_series ? '0 : pmin_reg;
        if ({1'b0, bp_c} >= p)
            bp_c = '0;

        fill_new = (fill_c < p) ? fill_c + 1'b1 : fill_c;
        blk_end  = ({1'b0, bp_c} == p - 1'b1);

        if (bp_c == '0)
        begin
            pmax_new = s;
            pmin_new = s;
        end
        else
        begin
            pmax_new = (s > pmax_c) ? s : pmax_c;
            pmin_new = (s < pmin_c) ? s : pmin_c;
        end
        emit = blk_end || (fill_new >= p);

        cmd.block_end = blk_end;
        cmd.emit      = emit;
        cmd.addr      = bp_c;
        cmd.sample    = s;
        cmd.pmax      = pmax_new;
        cmd.pmin      = pmin_new;
        cmd.index     = rcnt_c;

        wlen_next = wlen_reg;
        bp_next   = bp_reg;
        fill_next = fill_reg;
        rcnt_next = rcnt_reg;
        pmax_next = pmax_reg;
        pmin_next = pmin_reg;

        if (cfg_valid)
        begin
            wlen_next = cfg_data;
            bp_next   = '0;
            fill_next = '0;
            rcnt_next = '0;
            pmax_next = '0;
            pmin_next = '0;
        end
        else if (accept)
        begin
            if (in_data.last_of_series)
            begin
                bp_next   = '0;
                fill_next = '0;
                rcnt_next = '0;
                pmax_next = '0;
                pmin_next = '0;
            end
            else
            begin
                bp_next   = blk_end ? '0 : bp_c + 1'b1;
                fill_next = fill_new;
                rcnt_next = (emit && rcnt_c != '1) ? rcnt_c + 1'b1 : rcnt_c;
                // a completing sample leaves the prefix alone
                pmax_next = blk_end ? pmax_c : pmax_new;
                pmin_next = blk_end ? pmin_c : pmin_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_W'(WLEN_RESET);
            bp_reg   <= '0;
            fill_reg <= '0;
            rcnt_reg <= '0;
            pmax_reg <= '0;
            pmin_reg <= '0;
        end
        else
        begin
            wlen_reg <= wlen_next;
            bp_reg   <= bp_next;
            fill_reg <= fill_next;
            rcnt_reg <= rcnt_next;
            pmax_reg <= pmax_next;
            pmin_reg <= pmin_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rmm_cmd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmm_cmd_queue: command queue between front and back
// Small register FIFO that lets the front keep taking samples during a pass.
// ----------------------------------------------------------------------------
module rmm_cmd_queue
    import rmm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  cmd_t              push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output cmd_t              pop_data,
    output logic [QCNT_W-1:0] count
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign count      = cnt_reg;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== hdl/rmm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmm_back: block memory, suffix pass and result stage
// Stores block samples, runs the backward suffix extrema pass when a block
// completes, and combines stored suffix extrema with prefix extrema.
// ----------------------------------------------------------------------------
module rmm_back
    import rmm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    output bk_status_t status
);

    logic signed [SAMPLE_W-1:0] samp_mem    [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] sfx_max_mem [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] sfx_min_mem [MAX_WINDOW];

    bk_state_t                  state_reg, state_next;
    logic signed [SAMPLE_W-1:0] samp_rdata_reg;
    logic signed [SAMPLE_W-1:0] sfx_max_rdata_reg, sfx_min_rdata_reg;

    logic [ADDR_W-1:0]          rd_addr_reg, rd_addr_next;
    logic                       rd_active_reg, rd_active_next;
    logic [ADDR_W-1:0]          wr_addr_reg, wr_addr_next;
    logic                       wr_pend_reg, wr_pend_next;
    logic signed [SAMPLE_W-1:0] run_max_reg, run_max_next;
    logic signed [SAMPLE_W-1:0] run_min_reg, run_min_next;
    logic [INDEX_W-1:0]         end_index_reg, end_index_next;

    logic                       b_valid_reg, b_valid_next;
    logic                       b_emit_reg, b_emit_next;
    logic                       b_use_sfx_reg, b_use_sfx_next;
    logic signed [SAMPLE_W-1:0] b_pmax_reg, b_pmax_next;
    logic signed [SAMPLE_W-1:0] b_pmin_reg, b_pmin_next;
    logic [INDEX_W-1:0]         b_index_reg, b_index_next;

    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_data_reg, out_data_next;

    logic                       pop, b_adv, b_free;
    logic                       samp_re, sfx_re, sfx_we;
    logic [ADDR_W-1:0]          sfx_ra, sfx_wa;
    logic signed [SAMPLE_W-1:0] sfx_wmax, sfx_wmin;
    logic signed [SAMPLE_W-1:0] hi, lo, mx_new, mn_new;

    assign cmd_ready      = pop;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;
    assign status.in_pass = (state_reg == BK_PASS);
    assign status.pop     = pop;

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        samp_re        = 1'b0;
        sfx_re         = 1'b0;
        sfx_we         = 1'b0;
        sfx_ra         = cmd.addr + 1'b1;
        sfx_wa         = cmd.addr;
        sfx_wmax       = cmd.sample;
        sfx_wmin       = cmd.sample;
        rd_addr_next   = rd_addr_reg;
        rd_active_next = rd_active_reg;
        wr_addr_next   = wr_addr_reg;
        wr_pend_next   = wr_pend_reg;
        run_max_next   = run_max_reg;
        run_min_next   = run_min_reg;
        end_index_next = end_index_reg;

        mx_new = (samp_rdata_reg > run_max_reg) ? samp_rdata_reg : run_max_reg;
        mn_new = (samp_rdata_reg < run_min_reg) ? samp_rdata_reg : run_min_reg;

        // result stage: merge prefix extrema with the suffix of the last block
        hi = b_pmax_reg;
        lo = b_pmin_reg;
        if (b_use_sfx_reg && sfx_max_rdata_reg > b_pmax_reg)
            hi = sfx_max_rdata_reg;
        if (b_use_sfx_reg && sfx_min_rdata_reg < b_pmin_reg)
            lo = sfx_min_rdata_reg;

        b_adv  = b_valid_reg && (!b_emit_reg || !out_valid_reg || out_ready);
        b_free = !b_valid_reg || b_adv;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (b_adv && b_emit_reg)
        begin
            out_valid_next             = 1'b1;
            out_data_next.extreme_sum  = SUM_W'(hi) + SUM_W'(lo);
            out_data_next.output_index = b_index_reg;
        end

        b_valid_next   = b_valid_reg && !b_adv;
        b_emit_next    = b_emit_reg;
        b_use_sfx_next = b_use_sfx_reg;
        b_pmax_next    = b_pmax_reg;
        b_pmin_next    = b_pmin_reg;
        b_index_next   = b_index_reg;

        unique case (state_reg)
            BK_RUN:
            begin
                if (cmd_valid && b_free)
                begin
                    pop = 1'b1;
                    if (cmd.block_end)
                    begin
                        // last entry of the suffix is the sample itself
                        sfx_we         = 1'b1;
                        run_max_next   = cmd.sample;
                        run_min_next   = cmd.sample;
                        end_index_next = cmd.index;
                        rd_addr_next   = cmd.addr - 1'b1;
                        rd_active_next = (cmd.addr != '0);
                        wr_pend_next   = 1'b0;
                        state_next     = BK_PASS;
                    end
                    else
                    begin
                        sfx_re         = 1'b1;
                        b_valid_next   = 1'b1;
                        b_emit_next    = cmd.emit;
                        b_use_sfx_next = 1'b1;
                        b_pmax_next    = cmd.pmax;
                        b_pmin_next    = cmd.pmin;
                        b_index_next   = cmd.index;
                    end
                end
            end
            BK_PASS:
            begin
                // read one entry ahead, fold and write back the one before
                if (rd_active_reg)
                begin
                    samp_re        = 1'b1;
                    wr_pend_next   = 1'b1;
                    wr_addr_next   = rd_addr_reg;
                    rd_active_next = (rd_addr_reg != '0);
                    rd_addr_next   = rd_addr_reg - 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                end
                if (wr_pend_reg)
                begin
                    sfx_we       = 1'b1;
                    sfx_wa       = wr_addr_reg;
                    sfx_wmax     = mx_new;
                    sfx_wmin     = mn_new;
                    run_max_next = mx_new;
                    run_min_next = mn_new;
                end
                if (!rd_active_reg && !wr_pend_reg)
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (b_free)
                begin
                    b_valid_next   = 1'b1;
                    b_emit_next    = 1'b1;
                    b_use_sfx_next = 1'b0;
                    b_pmax_next    = run_max_reg;
                    b_pmin_next    = run_min_reg;
                    b_index_next   = end_index_reg;
                    state_next     = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            rd_active_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_active_reg <= rd_active_next;
            wr_pend_reg   <= wr_pend_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        wr_addr_reg   <= wr_addr_next;
        run_max_reg   <= run_max_next;
        run_min_reg   <= run_min_next;
        end_index_reg <= end_index_next;
        b_emit_reg    <= b_emit_next;
        b_use_sfx_reg <= b_use_sfx_next;
        b_pmax_reg    <= b_pmax_next;
        b_pmin_reg    <= b_pmin_next;
        b_index_reg   <= b_index_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            samp_mem[cmd.addr] <= cmd.sample;
        if (samp_re)
            samp_rdata_reg <= samp_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sfx_we)
        begin
            sfx_max_mem[sfx_wa] <= sfx_wmax;
            sfx_min_mem[sfx_wa] <= sfx_wmin;
        end
        if (sfx_re)
        begin
            sfx_max_rdata_reg <= sfx_max_mem[sfx_ra];
            sfx_min_rdata_reg <= sfx_min_mem[sfx_ra];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rolling_midpoint_min_max.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_midpoint_min_max: sliding window max+min (block suffix/prefix)
// Sums the maximum and minimum of the last window_length samples.
//
//   channel | signals                      | payload
//   --------+------------------------------+------------------------------
//   in      | in_valid / in_ready          | in_data (sample, flags)
//   out     | out_valid / out_ready        | out_data (extreme_sum, index)
//   cfg     | cfg_valid / cfg_ready        | cfg_data (window_length)
//
// A sample inside a block goes straight to the result stage; the sample that
// completes a block starts the backward suffix pass, which reads the block
// memory one entry per cycle while the back end takes no new commands.
// A 4-entry command queue lets the front keep taking samples during a pass.
// Reset clears control state only; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module rolling_midpoint_min_max
    import rmm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WLEN_W-1:0] cfg_data
);

    cmd_t              f_cmd, q_cmd;
    logic              f_cmd_valid, f_cmd_ready;
    logic              q_valid, q_ready;
    logic [QCNT_W-1:0] q_count;
    bk_status_t        bk_status;

    rmm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_valid (f_cmd_valid),
        .cmd_ready (f_cmd_ready),
        .cmd       (f_cmd)
    );

    rmm_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_cmd_valid),
        .push_ready (f_cmd_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd),
        .count      (q_count)
    );

    rmm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .status    (bk_status)
    );

    // no command leaves the queue while the suffix pass owns the memories
    a_pass_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.in_pass |-> !bk_status.pop)
        else $error("command transfer during suffix pass");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.pop |-> q_valid)
        else $error("back end took a command from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count beyond depth");

    a_pass_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(bk_status.in_pass) |-> !bk_status.pop)
        else $error("command transfer in the cycle a pass finishes");

endmodule
`default_nettype wire

// ===== verif/rolling_midpoint_min_max_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_midpoint_min_max_tb: self-checking bench for the sliding window max+min
// Queued samples are driven on the input channel, and every input transfer
// updates a local block suffix/prefix window model. Each result transfer is
// checked against the oldest predicted sum and index. The window length is
// rewritten between drained phases, including 0 and 2047, which clamp.
// ----------------------------------------------------------------------------
module rolling_midpoint_min_max_tb;
    import rmm_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    in_item_t          in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WLEN_W-1:0] cfg_data = '0;

    in_item_t  pending_samples[$];
    out_item_t expected_sums[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // Window lengths visited by the random part, in order
    int phase_wlen [19] = '{2, 1, 3, 0, 5, 4, 13, 7, 1024, 16, 31, 8, 2, 2047, 6, 24, 64,
                            9, 3};

    // Window model state
    logic signed [SAMPLE_W-1:0] held_samples [0:MAX_WINDOW-1];
    logic signed [SAMPLE_W-1:0] tail_max [0:MAX_WINDOW-1];
    logic signed [SAMPLE_W-1:0] tail_min [0:MAX_WINDOW-1];
    logic signed [SAMPLE_W-1:0] head_max = '0;
    logic signed [SAMPLE_W-1:0] head_min = '0;
    int unsigned                block_pos = 0;
    int unsigned                filled = 0;
    logic [INDEX_W-1:0]         emitted = '0;
    logic [WLEN_W-1:0]          wlen_reg = WLEN_W'(WLEN_RESET);

    rolling_midpoint_min_max uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned window_span();
        if (wlen_reg == 0)
            return 1;
        if (wlen_reg > MAX_WINDOW)
            return MAX_WINDOW;
        return 32'(wlen_reg);
    endfunction

    task automatic restart_window();
        head_max  = '0;
        head_min  = '0;
        block_pos = 0;
        filled    = 0;
        emitted   = '0;
    endtask

    task automatic configure_window(input logic [WLEN_W-1:0] value);
        wlen_reg = value;
        restart_window();
    endtask

    task automatic advance_window(input in_item_t item);
        int unsigned                span;
        logic signed [SAMPLE_W-1:0] s;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] run_max;
        logic signed [SAMPLE_W-1:0] run_min;
        logic signed [SUM_W-1:0]    total;
        bit                         emit;
        out_item_t                  res;
        span = window_span();
        s = item.sample;
        if (item.first_of_series)
            restart_window();
        if (block_pos >= span)
            block_pos = 0;
        held_samples[block_pos] = s;
        if (filled < span)
            filled++;
        if (block_pos == span - 1)
        begin
            // block complete: rebuild suffix extrema back to front
            run_max = s;
            run_min = s;
            for (int i = int'(span) - 1; i >= 0; i--)
            begin
                if (held_samples[i] > run_max)
                    run_max = held_samples[i];
                if (held_samples[i] < run_min)
                    run_min = held_samples[i];
                tail_max[i] = run_max;
                tail_min[i] = run_min;
            end
            hi = tail_max[0];
            lo = tail_min[0];
            emit = 1'b1;
            block_pos = 0;
        end
        else
        begin
            if (block_pos == 0)
            begin
                head_max = s;
                head_min = s;
            end
            else
            begin
                if (s > head_max)
                    head_max = s;
                if (s < head_min)
                    head_min = s;
            end
            hi = tail_max[block_pos + 1];
            lo = tail_min[block_pos + 1];
            if (head_max > hi)
                hi = head_max;
            if (head_min < lo)
                lo = head_min;
            emit = (filled >= span);
            block_pos++;
        end
        if (emit)
        begin
            total = hi + lo;
            res.extreme_sum  = total;
            res.output_index = emitted;
            if (emitted != '1)
                emitted++;
            expected_sums.push_back(res);
        end
        if (item.last_of_series)
            restart_window();
    endtask

    function automatic in_item_t make_item(input logic [SAMPLE_W-1:0] s, input bit first,
                                           input bit last);
        in_item_t item;
        item.sample          = s;
        item.first_of_series = first;
        item.last_of_series  = last;
        return item;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return 32'($urandom_range(20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    // Mostly clean series; a few get random flags to cut or merge series
    task automatic queue_series(input int len);
        bit ragged;
        bit first;
        bit last;
        ragged = ($urandom_range(99) < 15);
        for (int i = 0; i < len; i++)
        begin
            if (ragged)
            begin
                first = ($urandom_range(7) == 0);
                last  = ($urandom_range(7) == 0);
            end
            else
            begin
                first = (i == 0);
                last  = (i == len - 1);
            end
            pending_samples.push_back(make_item(pick_sample(), first, last));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_sums.size() != 0);
        // let trailing no-result samples retire
        repeat (window_span() + 64) @(posedge clk);
    endtask

    task automatic write_window_length(input logic [WLEN_W-1:0] value);
        wait_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        configure_window(value);
    endtask

    // Input driver: hold the item until its transfer, then maybe idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                advance_window(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_samples.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_results
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("unexpected result: extreme_sum %0d output_index %0d",
                           out_data.extreme_sum, out_data.output_index);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (out_data.extreme_sum !== want.extreme_sum)
                    begin
                        $error("extreme_sum: expected %0d, actual %0d",
                               want.extreme_sum, out_data.extreme_sum);
                        mismatch_count++;
                    end
                    if (out_data.output_index !== want.output_index)
                    begin
                        $error("output_index: expected %0d, actual %0d",
                               want.output_index, out_data.output_index);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        int span_now;
        int budget;
        int queued;
        int lo_len;
        int hi_len;
        int len;
        int mode;
        foreach (held_samples[i])
        begin
            held_samples[i] = '0;
            tail_max[i]     = '0;
            tail_min[i]     = '0;
        end
        send_idle_pct = 25;
        recv_idle_pct = 57;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset length 14: extremes of the sample range, then a series cut
        @(negedge clk);
        pending_samples.push_back(make_item(32'h7FFF_FFFF, 1'b1, 1'b0));
        pending_samples.push_back(make_item(32'h8000_0000, 1'b0, 1'b0));
        pending_samples.push_back(make_item(32'hFFFF_FFFF, 1'b0, 1'b0));
        pending_samples.push_back(make_item(32'h0000_0000, 1'b0, 1'b0));
        for (int i = 1; i <= 10; i++)
            pending_samples.push_back(make_item(32'(i), 1'b0, 1'b0));
        pending_samples.push_back(make_item(32'h5555_5555, 1'b0, 1'b0));
        pending_samples.push_back(make_item(32'hAAAA_AAAA, 1'b0, 1'b1));
        pending_samples.push_back(make_item(32'h0000_0003, 1'b1, 1'b0));

        // Length 0 acts as one: each sample doubles; both flags on one sample
        write_window_length(11'd0);
        @(negedge clk);
        pending_samples.push_back(make_item(32'h7FFF_FFFF, 1'b0, 1'b0));
        pending_samples.push_back(make_item(32'h8000_0000, 1'b0, 1'b0));
        pending_samples.push_back(make_item(32'hFFFF_FFFB, 1'b1, 1'b1));
        pending_samples.push_back(make_item(32'h0000_0000, 1'b0, 1'b0));

        for (int k = 0; k < $size(phase_wlen); k++)
        begin
            write_window_length(WLEN_W'(phase_wlen[k]));
            mode = k * 3 / $size(phase_wlen);
            case (mode)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            span_now = window_span();
            if (span_now >= 512)
                budget = 40;
            else
                budget = (span_now + 10 > 28) ? span_now + 10 : 28;
            lo_len = (span_now > 1) ? span_now - 1 : 1;
            if (lo_len > budget)
                lo_len = budget;
            hi_len = (3 * span_now + 4 < budget) ? 3 * span_now + 4 : budget;
            @(negedge clk);
            queued = 0;
            while (queued < budget)
            begin
                len = $urandom_range(hi_len, lo_len);
                if (len > budget - queued)
                    len = budget - queued;
                queue_series(len);
                queued += len;
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
